### sv/qpht_pkg.sv
package qpht_pkg;

    // Field widths fixed by the interface
    localparam int KEY_W  = 31;
    localparam int CFG_W  = 8;
    localparam int SLOT_W = 7;

    // Table size after reset
    localparam logic [CFG_W-1:0] TS_RESET = 8'd128;

    // Request codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    // Result codes
    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_FOUND    = 2'd2,
        ST_MISSING  = 2'd3
    } t_status;

endpackage

### sv/qpht_rem.sv
// Restoring remainder unit: one dividend bit per cycle.
module qpht_rem import qpht_pkg::*; #(
    parameter int NW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [KEY_W-1:0]  i_dividend,
    input  logic [NW-1:0]     i_divisor,
    output logic              o_done,
    output logic [NW-1:0]     o_rem
);

    localparam int CNT_W = $clog2(KEY_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [KEY_W-1:0] r_quo;
    logic [NW-1:0]    r_rem;

    logic [NW:0]      w_trial;
    logic [NW-1:0]    n_rem;

    // Shift in the next dividend bit, subtract the divisor when it fits
    always_comb begin
        w_trial = {r_rem, r_quo[KEY_W-1]};
        if (w_trial >= {1'b0, i_divisor}) begin
            n_rem = NW'(w_trial - {1'b0, i_divisor});
        end else begin
            n_rem = NW'(w_trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(KEY_W - 1);
                r_quo  <= i_dividend;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[KEY_W-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

### sv/quadratic_probe_hash_table.sv
// Operation: the remainder unit computes the home slot, then each probe takes a
// memory read (S_READ) and a check (S_CHECK), at most n probes with n the effective
// table size (one memory read per probe), and S_EMIT loads the result.
// Flow: one beat at a time; the input stalls until the result is registered,
// and S_EMIT waits longer while an earlier result stalls.
// Reset: synchronous, active low; afterwards a clearing pass over all TABLE_DEPTH
// slots empties every slot while the input stalls.
module quadratic_probe_hash_table import qpht_pkg::*; #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_action,
    input  logic [KEY_W-1:0]  i_key,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_status,
    output logic [SLOT_W-1:0] o_slot
);

    localparam int NW     = ($clog2(TABLE_DEPTH + 1) < 2) ? 2 : $clog2(TABLE_DEPTH + 1);
    localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW     = (NW > CFG_W) ? NW : CFG_W;
    localparam int WORD_W = KEY_W + 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_READ,
        S_CHECK,
        S_EMIT
    } t_state;

    t_state            r_state;
    logic [CFG_W-1:0]  r_table_size;
    logic [AW-1:0]     r_clr;
    logic              r_action;
    logic [KEY_W-1:0]  r_key;
    logic [NW-1:0]     r_home;
    logic [NW-1:0]     r_sq;
    logic [NW-1:0]     r_odd;
    logic [NW-1:0]     r_left;
    logic [WORD_W-1:0] r_rd;
    t_status           r_res_status;
    logic [SLOT_W-1:0] r_res_slot;
    logic              r_out_valid;
    t_status           r_out_status;
    logic [SLOT_W-1:0] r_out_slot;

    logic [WORD_W-1:0] mem [TABLE_DEPTH];

    logic [CW-1:0]     w_ts_ext;
    logic [NW-1:0]     w_n;
    logic [NW-1:0]     w_idx;
    logic [NW-1:0]     n_sq;
    logic [NW-1:0]     w_odd_tmp;
    logic [NW-1:0]     n_odd;
    logic              w_accept;
    logic              w_div_done;
    logic [NW-1:0]     w_div_rem;
    logic              w_used;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [WORD_W-1:0] w_wdata;

    // (a + b) mod m for a, b < m
    function automatic logic [NW-1:0] mod_add(input logic [NW-1:0] a,
                                              input logic [NW-1:0] b,
                                              input logic [NW-1:0] m);
        logic [NW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[NW-1:0];
    endfunction

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= TS_RESET;
        end else if (i_cfg_we) begin
            r_table_size <= i_cfg_wdata;
        end
    end

    // Effective size, saturated to 1..TABLE_DEPTH
    always_comb begin
        w_ts_ext = CW'(r_table_size);
        if (w_ts_ext == '0) begin
            w_n = NW'(1);
        end else if (w_ts_ext > CW'(TABLE_DEPTH)) begin
            w_n = NW'(TABLE_DEPTH);
        end else begin
            w_n = NW'(w_ts_ext);
        end
    end

    // Probe address and incremental square: sq += odd, odd += 2, all mod n
    always_comb begin
        w_idx     = mod_add(r_home, r_sq, w_n);
        n_sq      = mod_add(r_sq, r_odd, w_n);
        w_odd_tmp = mod_add(r_odd, NW'(2), w_n);
        n_odd     = (w_odd_tmp >= w_n) ? '0 : w_odd_tmp;
    end

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign w_used     = r_rd[KEY_W];

    // Home slot: key mod n
    qpht_rem #(
        .NW(NW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_dividend (i_key),
        .i_divisor  (w_n),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem)
    );

    // Slot memory write port: clearing pass or insert
    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_idx[AW-1:0];
        w_wdata = {1'b1, r_key};
        if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wdata = '0;
        end else if (r_state == S_CHECK && !w_used && r_action == ACT_INSERT) begin
            w_we = 1'b1;
        end
    end

    // Slot memory: used bit over key, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rd <= mem[w_idx[AW-1:0]];
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // result beat taken; S_EMIT handles its own reload
            if (r_out_valid && !i_out_stall && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(TABLE_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_action <= i_action;
                        r_key    <= i_key;
                        r_state  <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_home  <= w_div_rem;
                        r_sq    <= '0;
                        r_odd   <= (w_n == NW'(1)) ? '0 : NW'(1);
                        r_left  <= w_n;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    priority if (!w_used) begin
                        r_res_status <= (r_action == ACT_INSERT) ? ST_INSERTED : ST_MISSING;
                        r_res_slot   <= (r_action == ACT_INSERT) ? SLOT_W'(w_idx) : '0;
                        r_state      <= S_EMIT;
                    end else if (r_action == ACT_SEARCH && r_rd[KEY_W-1:0] == r_key) begin
                        r_res_status <= ST_FOUND;
                        r_res_slot   <= SLOT_W'(w_idx);
                        r_state      <= S_EMIT;
                    end else if (r_left == NW'(1)) begin
                        // every probe used up
                        r_res_status <= (r_action == ACT_INSERT) ? ST_FULL : ST_MISSING;
                        r_res_slot   <= '0;
                        r_state      <= S_EMIT;
                    end else begin
                        r_sq    <= n_sq;
                        r_odd   <= n_odd;
                        r_left  <= r_left - 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_slot   <= r_res_slot;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_slot      = r_out_slot;

endmodule

### sv/qpht_checker.sv
module qpht_checker import qpht_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_cfg_we,
    input logic [CFG_W-1:0]  i_cfg_wdata,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              i_action,
    input logic [KEY_W-1:0]  i_key,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [1:0]        o_status,
    input logic [SLOT_W-1:0] o_slot
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status) && $stable(o_slot))
        else $error("result beat changed while stalled");

    // Block is busy right after taking a beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accept");

    // The home slot is computed before any probe, so no result appears right after an accept
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !$rose(o_out_valid))
        else $error("result appeared one cycle after accept");

    // No slot is reported for full or not found
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FULL || o_status == ST_MISSING) |-> o_slot == '0)
        else $error("nonzero slot with full or not found");

    // Output empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind quadratic_probe_hash_table qpht_checker u_qpht_checker (.*);
